### sv/ngh_pkg.sv
// Shared types, constants and codes for the noise gate with hold.
`timescale 1ns / 1ps

package ngh_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 17;
    localparam int COEFF_W     = 16;
    localparam int HOLD_W      = 20;
    localparam int THRESH_W    = 24;
    localparam int MUL_A_W     = SAMPLE_W + 1;
    localparam int MUL_B_W     = GAIN_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 17'd65536;
    localparam logic [GAIN_W-1:0] SNAP_OPEN   = 17'd65470;
    localparam logic [GAIN_W-1:0] SNAP_CLOSED = 17'd66;

    localparam logic [CFG_INDEX_W-1:0] REG_GATE_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEFF    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEFF   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LENGTH     = 3'd4;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 24'd8389;

    typedef enum logic [2:0] {
        PH_CLOSED  = 3'd0,
        PH_OPENING = 3'd1,
        PH_OPEN    = 3'd2,
        PH_HOLDING = 3'd3,
        PH_CLOSING = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CTL_IDLE  = 3'd0,
        CTL_ENV   = 3'd1,
        CTL_GAIN  = 3'd2,
        CTL_UPD   = 3'd3,
        CTL_SCALE = 3'd4
    } ctl_state_t;

    typedef struct packed {
        logic                gate_enable;
        logic [THRESH_W-1:0] threshold_level;
        logic [COEFF_W-1:0]  attack_coeff;
        logic [COEFF_W-1:0]  release_coeff;
        logic [HOLD_W-1:0]   hold_length;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic env;
        logic gain;
        logic upd;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic enabled;
        logic out_free;
    } dp_status_t;

endpackage

### sv/noise_gate_with_hold_core.sv
// Top level of the stereo noise gate with hold: configuration registers and core wiring.
`timescale 1ns / 1ps

// Stereo noise gate with hold, attack and release. Each input item is one
// frame of two signed 24-bit samples; each frame yields exactly one result
// item with both samples multiplied by the current gain (Q1.16, floor of
// sample * gain / 65536), the gain applied and the gate phase (0 closed,
// 1 opening, 2 open, 3 holding, 4 closing). A peak envelope jumps up to the
// frame's largest magnitude and decays with release_coeff; the gate opens
// when the envelope reaches threshold_level, holds for hold_length frames
// once it drops below, then closes. Steps of an enabled frame: accept,
// envelope products, gain product, phase update, sample scaling; the
// multiplying steps share one pair of 25x18 multipliers. With gate_enable
// low a frame goes from accept straight to sample scaling, passes unchanged
// with gain 65536 and leaves all gate state frozen. Only one frame is in
// the core at a time: the input stalls from acceptance until the scaling
// step emits the result, and longer while the scaling step waits for
// the output register to be taken. Write configuration registers only while
// the core is idle.

module noise_gate_with_hold_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic        [ngh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic        [ngh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [ngh_pkg::SAMPLE_W-1:0]     left_sample,
    input  logic signed [ngh_pkg::SAMPLE_W-1:0]     right_sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [ngh_pkg::SAMPLE_W-1:0]     gated_left,
    output logic signed [ngh_pkg::SAMPLE_W-1:0]     gated_right,
    output logic        [ngh_pkg::GAIN_W-1:0]       gain_now,
    output logic        [2:0]                       gate_phase
);

    ngh_pkg::cfg_t       cfg_reg;
    ngh_pkg::dp_cmd_t    cmd;
    ngh_pkg::dp_status_t status;

    // Register file: decode the index, keep the low bits of the data word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_enable     <= 1'b1;
            cfg_reg.threshold_level <= ngh_pkg::THRESHOLD_RESET;
            cfg_reg.attack_coeff    <= '0;
            cfg_reg.release_coeff   <= '0;
            cfg_reg.hold_length     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ngh_pkg::REG_GATE_ENABLE:
                begin
                    cfg_reg.gate_enable <= cfg_data[0];
                end
                ngh_pkg::REG_THRESHOLD_LEVEL:
                begin
                    cfg_reg.threshold_level <= cfg_data[ngh_pkg::THRESH_W-1:0];
                end
                ngh_pkg::REG_ATTACK_COEFF:
                begin
                    cfg_reg.attack_coeff <= cfg_data[ngh_pkg::COEFF_W-1:0];
                end
                ngh_pkg::REG_RELEASE_COEFF:
                begin
                    cfg_reg.release_coeff <= cfg_data[ngh_pkg::COEFF_W-1:0];
                end
                ngh_pkg::REG_HOLD_LENGTH:
                begin
                    cfg_reg.hold_length <= cfg_data[ngh_pkg::HOLD_W-1:0];
                end
                default:
                begin
                    // Drop writes to unused indexes.
                end
            endcase
        end
    end

    // Sequence each frame through the datapath steps.
    ngh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold samples, envelope, gate state and the output register.
    ngh_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .gated_left   (gated_left),
        .gated_right  (gated_right),
        .gain_now     (gain_now),
        .gate_phase   (gate_phase)
    );

endmodule

### sv/ngh_ctrl.sv
// Sequencer that steps one frame through the shared multiplier datapath.
`timescale 1ns / 1ps

module ngh_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ngh_pkg::dp_status_t status,
    output ngh_pkg::dp_cmd_t   cmd
);

    ngh_pkg::ctl_state_t state_reg;
    ngh_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ngh_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ngh_pkg::CTL_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.enabled ? ngh_pkg::CTL_ENV : ngh_pkg::CTL_SCALE;
                end
            end
            ngh_pkg::CTL_ENV:
            begin
                cmd.env    = 1'b1;
                state_next = ngh_pkg::CTL_GAIN;
            end
            ngh_pkg::CTL_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ngh_pkg::CTL_UPD;
            end
            ngh_pkg::CTL_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ngh_pkg::CTL_SCALE;
            end
            ngh_pkg::CTL_SCALE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ngh_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = ngh_pkg::CTL_IDLE;
            end
        endcase
    end

    // A blocked result keeps the sequencer parked on the scaling step.
    a_scale_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ngh_pkg::CTL_SCALE && !status.out_free)
            |=> (state_reg == ngh_pkg::CTL_SCALE))
        else $error("sequencer left the scaling step while the output was full");

    // A disabled frame skips the gate update entirely.
    a_bypass_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !status.enabled) |=> (state_reg == ngh_pkg::CTL_SCALE))
        else $error("disabled frame did not go straight to scaling");

endmodule

### sv/ngh_datapath.sv
// Envelope, gate phase, gain and sample scaling on a shared pair of multipliers.
`timescale 1ns / 1ps

module ngh_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ngh_pkg::cfg_t                        cfg,
    input  ngh_pkg::dp_cmd_t                     cmd,
    output ngh_pkg::dp_status_t                  status,
    input  logic signed [ngh_pkg::SAMPLE_W-1:0]  left_sample,
    input  logic signed [ngh_pkg::SAMPLE_W-1:0]  right_sample,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic signed [ngh_pkg::SAMPLE_W-1:0]  gated_left,
    output logic signed [ngh_pkg::SAMPLE_W-1:0]  gated_right,
    output logic        [ngh_pkg::GAIN_W-1:0]    gain_now,
    output logic        [2:0]                    gate_phase
);

    localparam int SW = ngh_pkg::SAMPLE_W;
    localparam int GW = ngh_pkg::GAIN_W;
    localparam int PW = ngh_pkg::PROD_W;

    logic signed [SW-1:0]          left_reg;
    logic signed [SW-1:0]          right_reg;
    logic        [SW-1:0]          peak_reg;
    logic                          bypass_reg;
    logic        [SW-1:0]          env_reg;
    logic        [GW-1:0]          gain_reg;
    logic        [GW-1:0]          gain_next;
    ngh_pkg::phase_t               phase_reg;
    ngh_pkg::phase_t               phase_next;
    logic        [ngh_pkg::HOLD_W-1:0] hold_reg;
    logic        [ngh_pkg::HOLD_W-1:0] hold_next;
    logic signed [PW-1:0]          prod_a_reg;
    logic signed [PW-1:0]          prod_b_reg;
    logic                          out_valid_reg;
    logic signed [SW-1:0]          gated_left_reg;
    logic signed [SW-1:0]          gated_right_reg;
    logic        [GW-1:0]          gain_now_reg;
    logic        [2:0]             gate_phase_reg;

    logic        [SW-1:0]          mag_left;
    logic        [SW-1:0]          mag_right;
    logic        [GW-1:0]          scale_gain;
    logic signed [ngh_pkg::MUL_A_W-1:0] mul_a_x;
    logic signed [ngh_pkg::MUL_B_W-1:0] mul_a_y;
    logic signed [ngh_pkg::MUL_A_W-1:0] mul_b_x;
    logic signed [ngh_pkg::MUL_B_W-1:0] mul_b_y;
    logic signed [PW-1:0]          prod_a;
    logic signed [PW-1:0]          prod_b;
    logic        [PW-1:0]          env_sum;
    logic        [GW-1:0]          gain_step;
    logic        [GW:0]            gain_sum;
    logic                          above;
    logic        [ngh_pkg::HOLD_W-1:0] hold_dec;

    assign mag_left  = left_sample[SW-1]  ? (~left_sample + 1'b1)  : left_sample;
    assign mag_right = right_sample[SW-1] ? (~right_sample + 1'b1) : right_sample;

    assign scale_gain = bypass_reg ? ngh_pkg::GAIN_ONE : gain_reg;

    // Operand select for the two multipliers, one use per step.
    always_comb
    begin
        mul_a_x = '0;
        mul_a_y = '0;
        mul_b_x = '0;
        mul_b_y = '0;
        if (cmd.env)
        begin
            mul_a_x = {1'b0, env_reg};
            mul_a_y = {2'b00, cfg.release_coeff};
            mul_b_x = {1'b0, peak_reg};
            mul_b_y = {1'b0, ngh_pkg::GAIN_ONE - {1'b0, cfg.release_coeff}};
        end
        else if (cmd.gain)
        begin
            if (phase_reg == ngh_pkg::PH_OPENING)
            begin
                mul_a_x = {8'd0, ngh_pkg::GAIN_ONE - gain_reg};
                mul_a_y = {1'b0, ngh_pkg::GAIN_ONE - {1'b0, cfg.attack_coeff}};
            end
            else
            begin
                mul_a_x = {8'd0, gain_reg};
                mul_a_y = {2'b00, cfg.release_coeff};
            end
        end
        else
        begin
            mul_a_x = {left_reg[SW-1], left_reg};
            mul_a_y = {1'b0, scale_gain};
            mul_b_x = {right_reg[SW-1], right_reg};
            mul_b_y = {1'b0, scale_gain};
        end
    end

    assign prod_a = mul_a_x * mul_a_y;
    assign prod_b = mul_b_x * mul_b_y;

    assign env_sum   = prod_a_reg + prod_b_reg;
    assign gain_step = prod_a_reg[32:16];
    assign gain_sum  = {1'b0, gain_reg} + {1'b0, gain_step};
    assign above     = (env_reg >= cfg.threshold_level);
    assign hold_dec  = (hold_reg != '0) ? (hold_reg - 1'b1) : '0;

    // Gate phase update on the fresh envelope and gain product.
    always_comb
    begin
        phase_next = phase_reg;
        gain_next  = gain_reg;
        hold_next  = hold_reg;
        unique case (phase_reg)
            ngh_pkg::PH_CLOSED:
            begin
                if (above)
                begin
                    phase_next = ngh_pkg::PH_OPENING;
                end
            end
            ngh_pkg::PH_OPENING:
            begin
                if (gain_sum >= {1'b0, ngh_pkg::SNAP_OPEN})
                begin
                    gain_next  = ngh_pkg::GAIN_ONE;
                    phase_next = ngh_pkg::PH_OPEN;
                end
                else
                begin
                    gain_next = gain_sum[GW-1:0];
                end
            end
            ngh_pkg::PH_OPEN:
            begin
                if (!above)
                begin
                    phase_next = ngh_pkg::PH_HOLDING;
                    hold_next  = cfg.hold_length;
                end
            end
            ngh_pkg::PH_HOLDING:
            begin
                if (above)
                begin
                    phase_next = ngh_pkg::PH_OPEN;
                end
                else
                begin
                    hold_next = hold_dec;
                    if (hold_dec == '0)
                    begin
                        phase_next = ngh_pkg::PH_CLOSING;
                    end
                end
            end
            ngh_pkg::PH_CLOSING:
            begin
                if (gain_step < ngh_pkg::SNAP_CLOSED)
                begin
                    gain_next  = '0;
                    phase_next = ngh_pkg::PH_CLOSED;
                end
                else
                begin
                    gain_next = gain_step;
                end
            end
            default:
            begin
                phase_next = ngh_pkg::PH_CLOSED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg       <= '0;
            gain_reg      <= '0;
            phase_reg     <= ngh_pkg::PH_CLOSED;
            hold_reg      <= '0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bypass_reg <= !cfg.gate_enable;
            end
            if (cmd.gain)
            begin
                env_reg <= (peak_reg > env_reg) ? peak_reg : env_sum[39:16];
            end
            if (cmd.upd)
            begin
                gain_reg  <= gain_next;
                phase_reg <= phase_next;
                hold_reg  <= hold_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
            peak_reg  <= (mag_left > mag_right) ? mag_left : mag_right;
        end
        if (cmd.env || cmd.gain)
        begin
            prod_a_reg <= prod_a;
        end
        if (cmd.env)
        begin
            prod_b_reg <= prod_b;
        end
        if (cmd.emit)
        begin
            gated_left_reg  <= prod_a[39:16];
            gated_right_reg <= prod_b[39:16];
            gain_now_reg    <= scale_gain;
            gate_phase_reg  <= phase_reg;
        end
    end

    assign status.enabled  = cfg.gate_enable;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign gated_left  = gated_left_reg;
    assign gated_right = gated_right_reg;
    assign gain_now    = gain_now_reg;
    assign gate_phase  = gate_phase_reg;

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= ngh_pkg::GAIN_ONE)
        else $error("gain above unity");

    a_closed_mute: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ngh_pkg::PH_CLOSED) |-> (gain_reg == '0))
        else $error("closed gate with nonzero gain");

    a_open_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ngh_pkg::PH_OPEN || phase_reg == ngh_pkg::PH_HOLDING)
            |-> (gain_reg == ngh_pkg::GAIN_ONE))
        else $error("open or holding gate below unity gain");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote an item not yet taken");

endmodule

### verif/tb.sv
// Self-checking testbench for the stereo noise gate with hold.
`timescale 1ns / 1ps

import ngh_pkg::*;

// One result item as the gate should deliver it.
typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [GAIN_W-1:0]          gain;
    logic [2:0]                 phase;
} gated_frame_t;

// Tracks envelope, gain, phase and hold count of the gate, and queues the
// result item that each accepted frame should produce.
class gate_follower;
    cfg_t                 cfg;
    logic [SAMPLE_W-1:0]  envelope;
    logic [GAIN_W-1:0]    gain;
    phase_t               phase;
    logic [HOLD_W-1:0]    hold_count;
    gated_frame_t         due[$];
    int                   errors;
    int                   checked;

    function new();
        cfg.gate_enable     = 1'b1;
        cfg.threshold_level = THRESHOLD_RESET;
        cfg.attack_coeff    = '0;
        cfg.release_coeff   = '0;
        cfg.hold_length     = '0;
        envelope   = '0;
        gain       = '0;
        phase      = PH_CLOSED;
        hold_count = '0;
        errors     = 0;
        checked    = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_GATE_ENABLE:     cfg.gate_enable     = value[0];
            REG_THRESHOLD_LEVEL: cfg.threshold_level = value[THRESH_W-1:0];
            REG_ATTACK_COEFF:    cfg.attack_coeff    = value[COEFF_W-1:0];
            REG_RELEASE_COEFF:   cfg.release_coeff   = value[COEFF_W-1:0];
            REG_HOLD_LENGTH:     cfg.hold_length     = value[HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return due.size();
    endfunction

    // floor(sample * gain / 65536), wrapped to the sample width
    function logic [SAMPLE_W-1:0] scaled(longint s, logic [GAIN_W-1:0] g);
        longint p;
        p = (s * longint'(g)) >>> 16;
        return p[SAMPLE_W-1:0];
    endfunction

    function void take_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        longint lv, rv, mag_l, mag_r, peak, mix, g;
        gated_frame_t want;
        lv = l;
        rv = r;
        mag_l = (lv < 0) ? -lv : lv;
        mag_r = (rv < 0) ? -rv : rv;
        peak  = (mag_l > mag_r) ? mag_l : mag_r;

        // disabled: pass through at unity, freeze everything
        if (!cfg.gate_enable)
        begin
            want.left  = l;
            want.right = r;
            want.gain  = GAIN_ONE;
            want.phase = phase;
            due.push_back(want);
            return;
        end

        // peak envelope: jump up at once, otherwise decay toward the peak
        if (peak > longint'(envelope))
        begin
            envelope = peak[SAMPLE_W-1:0];
        end
        else
        begin
            mix = longint'(envelope) * longint'(cfg.release_coeff)
                + peak * (65536 - longint'(cfg.release_coeff));
            envelope = mix[SAMPLE_W+15:16];
        end

        case (phase)
            PH_CLOSED:
            begin
                if (envelope >= cfg.threshold_level)
                    phase = PH_OPENING;
            end
            PH_OPENING:
            begin
                g = gain;
                g = g + (((65536 - g) * (65536 - longint'(cfg.attack_coeff))) >>> 16);
                if (g >= longint'(SNAP_OPEN))
                begin
                    g = GAIN_ONE;
                    phase = PH_OPEN;
                end
                gain = g[GAIN_W-1:0];
            end
            PH_OPEN:
            begin
                if (envelope < cfg.threshold_level)
                begin
                    phase = PH_HOLDING;
                    hold_count = cfg.hold_length;
                end
            end
            PH_HOLDING:
            begin
                if (envelope >= cfg.threshold_level)
                begin
                    phase = PH_OPEN;
                end
                else
                begin
                    if (hold_count != 0)
                        hold_count = hold_count - 1'b1;
                    if (hold_count == 0)
                        phase = PH_CLOSING;
                end
            end
            PH_CLOSING:
            begin
                g = (longint'(gain) * longint'(cfg.release_coeff)) >>> 16;
                if (g < longint'(SNAP_CLOSED))
                begin
                    g = 0;
                    phase = PH_CLOSED;
                end
                gain = g[GAIN_W-1:0];
            end
            default: phase = PH_CLOSED;
        endcase

        want.left  = scaled(lv, gain);
        want.right = scaled(rv, gain);
        want.gain  = gain;
        want.phase = phase;
        due.push_back(want);
    endfunction

    // Print one line per mismatch and count it.
    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_frame(logic signed [SAMPLE_W-1:0] gl, logic signed [SAMPLE_W-1:0] gr,
                     logic [GAIN_W-1:0] g, logic [2:0] ph);
        gated_frame_t want;
        if (due.size() == 0)
        begin
            report($sformatf("result with no frame due: left %0d right %0d gain %0d phase %0d",
                             gl, gr, g, ph));
            return;
        end
        want = due.pop_front();
        if (gl !== want.left)
            report($sformatf("frame %0d gated_left %0d, want %0d", checked, gl, want.left));
        if (gr !== want.right)
            report($sformatf("frame %0d gated_right %0d, want %0d", checked, gr, want.right));
        if (g !== want.gain)
            report($sformatf("frame %0d gain_now %0d, want %0d", checked, g, want.gain));
        if (ph !== want.phase)
            report($sformatf("frame %0d gate_phase %0d, want %0d", checked, ph, want.phase));
        checked++;
    endtask
endclass

module tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 12;     // margin for the core to finish its last frame and go idle
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'h800000;

    typedef enum int {LVL_QUIET, LVL_LOUD, LVL_NOISE, LVL_EDGE} level_kind_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  left_sample  = '0;
    logic signed [SAMPLE_W-1:0]  right_sample = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0]  gated_left;
    logic signed [SAMPLE_W-1:0]  gated_right;
    logic [GAIN_W-1:0]           gain_now;
    logic [2:0]                  gate_phase;

    gate_follower         tracker;
    bit                   calm = 1'b0;     // when set, neither side idles
    logic [THRESH_W-1:0]  cur_thr  = THRESHOLD_RESET;
    logic [HOLD_W-1:0]    cur_hold = '0;
    int                   cycles   = 0;
    int                   seg_left = 0;
    bit                   stall_now = 1'b0;

    noise_gate_with_hold_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gated_left   (gated_left),
        .gated_right  (gated_right),
        .gain_now     (gain_now),
        .gate_phase   (gate_phase)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop: a hang or a lost result ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Check every result item taken at this edge against the oldest one due.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_frame(gated_left, gated_right, gain_now, gate_phase);
    end

    // Output back-pressure: segments of stall / no stall, mostly short, a few long.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (seg_left == 0)
            begin
                if (calm)
                begin
                    stall_now = 1'b0;
                    seg_left  = 4;
                end
                else
                begin
                    stall_now = ($urandom_range(0, 2) == 0);
                    seg_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
                end
            end
            seg_left--;
            out_stall = stall_now;
        end
    end

    // Idle cycles before the next frame: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pick one sample of the given loudness relative to the current threshold.
    function automatic logic signed [SAMPLE_W-1:0] pick_level(level_kind_t kind);
        int unsigned cap, lo, mag, raw;
        logic signed [SAMPLE_W-1:0] v;
        mag = 0;
        case (kind)
            LVL_QUIET:
            begin
                if (cur_thr == 0)
                    cap = 0;
                else if (cur_thr > 24'd8388608)
                    cap = 8388607;
                else
                    cap = cur_thr - 1;
                if ($urandom_range(0, 1))
                    cap = cap / 16;
                mag = $urandom_range(0, cap);
            end
            LVL_LOUD:
            begin
                lo  = (cur_thr > 24'd8388608) ? 8388608 : cur_thr;
                mag = $urandom_range(lo, 8388608);
            end
            LVL_NOISE:
            begin
                raw = $urandom();
                return raw[SAMPLE_W-1:0];
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return FULL_NEG;
                    1: return FULL_POS;
                    2: return '0;
                    3: return '1;
                    default: return 24'sd1;
                endcase
            end
        endcase
        // only a negative sample can reach magnitude 2^23
        if (mag >= 8388608)
            return FULL_NEG;
        v = mag[SAMPLE_W-1:0];
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Write one register; call only while the core is idle.
    task automatic set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        tracker.set_reg(index, value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Offer one frame, hold it until taken, note it as accepted.
    task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge clk);
        in_valid     = 1'b1;
        left_sample  = l;
        right_sample = r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_frame(l, r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_level_frame(level_kind_t kind);
        level_kind_t other;
        logic signed [SAMPLE_W-1:0] a, b;
        // a loud frame has one loud channel; the other stays quiet
        if (kind == LVL_LOUD)
            other = LVL_QUIET;
        else
            other = kind;
        a = pick_level(kind);
        b = pick_level(other);
        if ($urandom_range(0, 1))
            send_frame(a, b);
        else
            send_frame(b, a);
    endtask

    // Hold the sender until every result is back, then let the core go idle.
    task automatic settle();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Hand-picked frames that walk the gate through every phase and corner.
    task automatic directed_frames();
        // an unmapped index must leave every register alone
        set_reg(REG_UNUSED, 24'hFFFFFF);
        // reset settings: threshold 8389, instant attack and release, no hold
        send_frame(0, 0);                        // closed, silence
        send_frame(FULL_POS, FULL_NEG);          // full-scale negative: envelope 2^23
        send_frame(FULL_POS, FULL_NEG);          // opening snaps straight to unity
        send_frame(-1, 1);                       // open -> holding
        send_frame(100, -100);                   // zero hold: straight to closing
        send_frame(0, 0);                        // closing snaps shut
        send_frame(8389, 0);                     // envelope exactly at threshold
        send_frame(-8389, 5);
        send_frame(-123456, 654321);             // open, unity gain
        // disabled: pass-through at unity with the phase frozen
        settle();
        set_reg(REG_GATE_ENABLE, 1'b0);
        send_frame(FULL_NEG, FULL_POS);
        send_frame(12345, -1);
        settle();
        set_reg(REG_GATE_ENABLE, 1'b1);
        set_reg(REG_HOLD_LENGTH, 2);
        send_frame(0, 0);                        // open -> holding, count 2
        send_frame(0, 0);
        send_frame(9000, 0);                     // back above threshold: reopen
        send_frame(0, 0);
        send_frame(0, 0);
        send_frame(0, 0);                        // count runs out: closing
        send_frame(0, 0);
        // half-way coefficients: fractional gain, floor on negative samples
        settle();
        set_reg(REG_ATTACK_COEFF, 32768);
        set_reg(REG_RELEASE_COEFF, 32768);
        send_frame(FULL_POS, FULL_POS);
        send_frame(-3, FULL_NEG);
        send_frame(-1, -1);
        send_frame(5, -5);
    endtask

    // One setting of all registers, then bursts of loud and quiet frames,
    // some noise and corner samples, and now and then a frozen stretch.
    task automatic run_phase(bit en, logic [THRESH_W-1:0] thr, logic [COEFF_W-1:0] att,
                             logic [COEFF_W-1:0] rel, logic [HOLD_W-1:0] hold, int items);
        int sent, len, quiet_len, pick;
        settle();
        set_reg(REG_GATE_ENABLE, en);
        set_reg(REG_THRESHOLD_LEVEL, thr);
        set_reg(REG_ATTACK_COEFF, att);
        set_reg(REG_RELEASE_COEFF, rel);
        set_reg(REG_HOLD_LENGTH, hold);
        cur_thr  = thr;
        cur_hold = hold;
        sent = 0;
        while (sent < items)
        begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                // open the gate, then let it fall through hold into closing
                len       = $urandom_range(1, 8);
                quiet_len = $urandom_range(1, (cur_hold < 16) ? cur_hold + 6 : 24);
                repeat (len) send_level_frame(LVL_LOUD);
                repeat (quiet_len) send_level_frame(LVL_QUIET);
                sent += len + quiet_len;
            end
            else if (pick < 92)
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_level_frame(LVL_NOISE);
                sent += len;
            end
            else if (pick < 97)
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_level_frame(LVL_EDGE);
                sent += len;
            end
            else
            begin
                // drain, freeze the gate wherever it stands, then resume
                settle();
                set_reg(REG_GATE_ENABLE, 1'b0);
                len = $urandom_range(1, 4);
                repeat (len) send_level_frame(LVL_NOISE);
                settle();
                set_reg(REG_GATE_ENABLE, en);
                sent += len;
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        tracker = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        directed_frames();

        run_phase(1'b1, 100000, 40000, 50000, 3, 150);
        // everything opens at threshold zero; slowest possible coefficients
        run_phase(1'b1, 0, 65535, 65535, 0, 60);
        // threshold beyond any envelope: the gate never opens
        run_phase(1'b1, 24'hFFFFFF, 0, 0, 0, 60);
        // top of the envelope range: only a full-scale negative sample opens
        run_phase(1'b1, 24'd8388608, 20000, 30000, 10, 80);
        repeat (3)
            run_phase(1'b1, $urandom_range(500, 2000000), $urandom_range(0, 65535),
                      $urandom_range(16384, 62000), $urandom_range(0, 12), 150);
        // longest hold: once holding, the gate only leaves by reopening
        run_phase(1'b1, 50000, 60000, 62000, 20'hFFFFF, 80);
        run_phase(1'b0, $urandom_range(0, 16777215), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 1048575), 60);
        run_phase(1'b1, 3000, 0, 0, 0, 120);

        settle();
        if (tracker.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
